// File: hw/rtl/miller_rabin_prime_test_64_macros.svh
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64_macros.svh
// Assertion macros shared by the primality test RTL.
// ----------------------------------------------------------------------------
`ifndef MILLER_RABIN_PRIME_TEST_64_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_64_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define MRPT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define MRPT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mrpt64_pkg.sv
// ----------------------------------------------------------------------------
// mrpt64_pkg
// Types, constants and the witness table of the 64-bit primality test.
// ----------------------------------------------------------------------------
package mrpt64_pkg;

    localparam int WORD_W            = 64;
    localparam int WIT_TABLE_SIZE    = 12;
    localparam int WITNESS_COUNT_DEF = 12;
    localparam int WIT_W             = 6;
    localparam int WIDX_W            = $clog2(WIT_TABLE_SIZE);
    localparam int CNT_W             = $clog2(WORD_W);

    localparam logic [WIT_W-1:0] SCREEN_DIV = WIT_W'(3);
    localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(WORD_W - 1);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [WIT_W-1:0]  wit_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCREEN,
        ST_MOD3,
        ST_SPLIT,
        ST_MODW,
        ST_POW_SQ,
        ST_SQ_WAIT,
        ST_POW_MUL,
        ST_MUL_WAIT,
        ST_POW_NEXT,
        ST_CHECK,
        ST_LOOP,
        ST_LOOP_WAIT,
        ST_NEXTW,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic square;
    } mm_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_sts_t;

    function automatic wit_t witness(input logic [WIDX_W-1:0] idx);
        wit_t w;
        case (idx)
            WIDX_W'(0):  w = WIT_W'(2);
            WIDX_W'(1):  w = WIT_W'(3);
            WIDX_W'(2):  w = WIT_W'(5);
            WIDX_W'(3):  w = WIT_W'(7);
            WIDX_W'(4):  w = WIT_W'(11);
            WIDX_W'(5):  w = WIT_W'(13);
            WIDX_W'(6):  w = WIT_W'(17);
            WIDX_W'(7):  w = WIT_W'(19);
            WIDX_W'(8):  w = WIT_W'(23);
            WIDX_W'(9):  w = WIT_W'(29);
            WIDX_W'(10): w = WIT_W'(31);
            WIDX_W'(11): w = WIT_W'(37);
            default:     w = WIT_W'(37);
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/mrpt64_mulmod.sv
// ----------------------------------------------------------------------------
// mrpt64_mulmod
// Bit-serial modular multiplier: x * y mod m, one multiplier bit per cycle,
// most significant bit first. y is x itself (square) or a small witness.
// ----------------------------------------------------------------------------
`include "miller_rabin_prime_test_64_macros.svh"

module mrpt64_mulmod
    import mrpt64_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  mm_ctl_t ctl,
    input  word_t   x,
    input  wit_t    w,
    input  word_t   m,
    output mm_sts_t sts,
    output word_t   result
);

    logic             run_reg,  run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    word_t            acc_reg,  acc_next;
    word_t            x_reg,    x_next;
    word_t            y_reg,    y_next;
    word_t            m_reg,    m_next;

    logic [WORD_W+1:0] s_sum;
    logic [WORD_W+1:0] s_less1;
    logic [WORD_W+1:0] s_less2;
    word_t             acc_step;

    always_comb begin
        s_sum    = {1'b0, acc_reg, 1'b0}
                 + (y_reg[WORD_W-1] ? {2'b00, x_reg} : {(WORD_W+2){1'b0}});
        s_less1  = s_sum - {2'b00, m_reg};
        s_less2  = s_sum - {1'b0, m_reg, 1'b0};
        if (!s_less2[WORD_W+1]) begin
            acc_step = s_less2[WORD_W-1:0];
        end else if (!s_less1[WORD_W+1]) begin
            acc_step = s_less1[WORD_W-1:0];
        end else begin
            acc_step = s_sum[WORD_W-1:0];
        end
    end

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        if (run_reg) begin
            acc_next = acc_step;
            y_next   = {y_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end else if (ctl.start) begin
            run_next = 1'b1;
            cnt_next = '0;
            acc_next = '0;
            x_next   = x;
            y_next   = ctl.square ? x : {{(WORD_W-WIT_W){1'b0}}, w};
            m_next   = m;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
    end

    assign sts.busy = run_reg;
    assign sts.done = done_reg;
    assign result   = acc_reg;

    `MRPT_ASSERT_NEXT(a_start_runs, aclk, aresetn, (ctl.start && !run_reg), run_reg, "multiplier did not start")
    `MRPT_ASSERT_NOW(a_acc_reduced, aclk, aresetn, (run_reg && (x_reg < m_reg)), (acc_reg < m_reg), "accumulator not reduced")
    `MRPT_ASSERT_NOW(a_done_after_run, aclk, aresetn, done_reg, ($fell(run_reg)), "done without finished run")

endmodule

// File: hw/rtl/miller_rabin_prime_test_64.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64
// Deterministic 64-bit primality test with a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// One number at a time. Numbers below 4, even numbers and multiples of 3 are
// answered by the screens. Every other number runs Miller-Rabin with
// up to WITNESS_COUNT witnesses (2 through 37); each witness costs a
// residue check, 64 exponent steps and up to 125 products in the one
// shared bit-serial multiplier (one multiplier bit per cycle): up to 62
// squarings and 63 multiplications by the witness for the power and up to
// 62 more squarings, fewer in all because the odd part and the trailing
// zeros of n - 1 share its 64 bits. Composites usually finish after the
// first witness. A result waits in the output register while the next
// number is taken.
`include "miller_rabin_prime_test_64_macros.svh"

module miller_rabin_prime_test_64
    import mrpt64_pkg::*;
#(
    parameter int WITNESS_COUNT = WITNESS_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] number
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] is_prime, [7:1] zero
);

    localparam int WIT_USED = (WITNESS_COUNT > WIT_TABLE_SIZE) ? WIT_TABLE_SIZE
                            : WITNESS_COUNT;
    localparam logic [WIDX_W-1:0] WIT_LAST = WIDX_W'(WIT_USED - 1);

    state_t            state_reg, state_next;
    word_t             n_reg,     n_next;
    word_t             nm1_reg,   nm1_next;
    word_t             e_reg,     e_next;
    word_t             pe_reg,    pe_next;
    word_t             acc_reg,   acc_next;
    word_t             sh_reg,    sh_next;
    logic [WIT_W-1:0]  r_reg,     r_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [CNT_W-1:0]  twos_reg,  twos_next;
    logic [WIDX_W-1:0] widx_reg,  widx_next;
    logic              res_reg,   res_next;
    logic              mval_reg,  mval_next;
    logic              prime_reg, prime_next;

    mm_ctl_t mm_ctl;
    mm_sts_t mm_sts;
    word_t   mm_result;
    wit_t    wit;
    wit_t    mod_div;
    logic [WIT_W:0] r_sum;
    wit_t    r_step;

    assign wit     = witness(widx_reg);
    assign mod_div = (state_reg == ST_MOD3) ? SCREEN_DIV : wit;

    always_comb begin
        r_sum = {r_reg, sh_reg[WORD_W-1]};
        if (r_sum >= {1'b0, mod_div}) begin
            r_sum = r_sum - {1'b0, mod_div};
        end
        r_step = r_sum[WIT_W-1:0];
    end

    mrpt64_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mm_ctl),
        .x       (acc_reg),
        .w       (wit),
        .m       (n_reg),
        .sts     (mm_sts),
        .result  (mm_result)
    );

    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        nm1_next      = nm1_reg;
        e_next        = e_reg;
        pe_next       = pe_reg;
        acc_next      = acc_reg;
        sh_next       = sh_reg;
        r_next        = r_reg;
        cnt_next      = cnt_reg;
        twos_next     = twos_reg;
        widx_next     = widx_reg;
        res_next      = res_reg;
        prime_next    = prime_reg;
        mval_next     = mval_reg && !m_axis_tready;
        mm_ctl.start  = 1'b0;
        mm_ctl.square = 1'b1;
        s_axis_tready = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_next     = s_axis_tdata;
                    nm1_next   = s_axis_tdata - WORD_W'(1);
                    state_next = ST_SCREEN;
                end
            end
            ST_SCREEN: begin
                if (n_reg[WORD_W-1:1] == '0) begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end else if (n_reg[WORD_W-1:2] == '0) begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end else if (!n_reg[0]) begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    r_next     = '0;
                    sh_next    = n_reg;
                    cnt_next   = '0;
                    state_next = ST_MOD3;
                end
            end
            ST_MOD3: begin
                r_next   = r_step;
                sh_next  = {sh_reg[WORD_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    if (r_step == '0) begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        e_next     = nm1_reg;
                        twos_next  = '0;
                        state_next = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT: begin
                if (!e_reg[0] && (twos_reg != CNT_LAST)) begin
                    e_next    = {1'b0, e_reg[WORD_W-1:1]};
                    twos_next = twos_reg + CNT_W'(1);
                end else begin
                    widx_next  = '0;
                    r_next     = '0;
                    sh_next    = n_reg;
                    cnt_next   = '0;
                    state_next = ST_MODW;
                end
            end
            ST_MODW: begin
                r_next   = r_step;
                sh_next  = {sh_reg[WORD_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    if (r_step == '0) begin
                        if (n_reg == {{(WORD_W-WIT_W){1'b0}}, wit}) begin
                            state_next = ST_NEXTW;
                        end else begin
                            res_next   = 1'b0;
                            state_next = ST_DONE;
                        end
                    end else begin
                        acc_next   = WORD_W'(1);
                        pe_next    = e_reg;
                        cnt_next   = '0;
                        state_next = ST_POW_SQ;
                    end
                end
            end
            ST_POW_SQ: begin
                if (acc_reg == WORD_W'(1)) begin
                    state_next = ST_POW_MUL;
                end else begin
                    mm_ctl.start = 1'b1;
                    state_next   = ST_SQ_WAIT;
                end
            end
            ST_SQ_WAIT: begin
                if (mm_sts.done) begin
                    acc_next   = mm_result;
                    state_next = ST_POW_MUL;
                end
            end
            ST_POW_MUL: begin
                if (pe_reg[WORD_W-1]) begin
                    mm_ctl.start  = 1'b1;
                    mm_ctl.square = 1'b0;
                    state_next    = ST_MUL_WAIT;
                end else begin
                    state_next = ST_POW_NEXT;
                end
            end
            ST_MUL_WAIT: begin
                if (mm_sts.done) begin
                    acc_next   = mm_result;
                    state_next = ST_POW_NEXT;
                end
            end
            ST_POW_NEXT: begin
                pe_next  = {pe_reg[WORD_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_CHECK;
                end else begin
                    state_next = ST_POW_SQ;
                end
            end
            ST_CHECK: begin
                if ((acc_reg == WORD_W'(1)) || (acc_reg == nm1_reg)) begin
                    state_next = ST_NEXTW;
                end else begin
                    cnt_next   = CNT_W'(1);
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP: begin
                if (cnt_reg >= twos_reg) begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    mm_ctl.start = 1'b1;
                    state_next   = ST_LOOP_WAIT;
                end
            end
            ST_LOOP_WAIT: begin
                if (mm_sts.done) begin
                    acc_next = mm_result;
                    if (mm_result == nm1_reg) begin
                        state_next = ST_NEXTW;
                    end else begin
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = ST_LOOP;
                    end
                end
            end
            ST_NEXTW: begin
                if (widx_reg == WIT_LAST) begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    widx_next  = widx_reg + WIDX_W'(1);
                    r_next     = '0;
                    sh_next    = n_reg;
                    cnt_next   = '0;
                    state_next = ST_MODW;
                end
            end
            ST_DONE: begin
                if (!mval_reg || m_axis_tready) begin
                    mval_next  = 1'b1;
                    prime_next = res_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mval_reg  <= 1'b0;
            cnt_reg   <= '0;
            twos_reg  <= '0;
            widx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
            cnt_reg   <= cnt_next;
            twos_reg  <= twos_next;
            widx_reg  <= widx_next;
        end
        n_reg     <= n_next;
        nm1_reg   <= nm1_next;
        e_reg     <= e_next;
        pe_reg    <= pe_next;
        acc_reg   <= acc_next;
        sh_reg    <= sh_next;
        r_reg     <= r_next;
        res_reg   <= res_next;
        prime_reg <= prime_next;
    end

    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = {7'b0, prime_reg};

    `MRPT_ASSERT_NOW(a_start_when_free, aclk, aresetn, mm_ctl.start,
        (!mm_sts.busy && !mm_sts.done), "multiplier started while busy")
    `MRPT_ASSERT_NOW(a_done_awaited, aclk, aresetn, mm_sts.done,
        ((state_reg == ST_SQ_WAIT) || (state_reg == ST_MUL_WAIT) || (state_reg == ST_LOOP_WAIT)),
        "product arrived unexpectedly")
    `MRPT_ASSERT_NOW(a_acc_below_n, aclk, aresetn, (state_reg == ST_POW_SQ),
        (acc_reg < n_reg), "accumulator not reduced")
    `MRPT_ASSERT_NOW(a_widx_range, aclk, aresetn, (state_reg == ST_MODW),
        (widx_reg <= WIT_LAST), "witness index out of range")

endmodule

// File: tb/miller_rabin_prime_test_64_tb.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64_tb
// Self-checking testbench for the streaming 64-bit primality test.
// ----------------------------------------------------------------------------
// A directed list covers the edges of the input range, the small primes, the
// even and multiple-of-three screens, the largest witness itself, Carmichael
// numbers and strong pseudoprimes to the leading bases. Random numbers follow,
// most of them odd and coprime to six so that they reach the witness loop:
// full-width values, values with long runs of trailing zeros in n - 1,
// products of two 32-bit primes and large primes. Each accepted number is
// run through a local Miller-Rabin predictor and the verdict is compared with
// the result stream in order. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_64_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrpt64_pkg::*;

    localparam longint unsigned CYCLE_LIMIT = 100_000_000;
    localparam int              RANDOM_ITEMS = 77;
    localparam int              NUM_BASES    = 12;
    localparam int              MAX_REPORTS  = 10;
    localparam logic [5:0]      BASES [NUM_BASES] =
        '{6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37};

    typedef struct {
        word_t       number;
        int unsigned gap;
        bit          drain_first;
    } candidate_t;

    typedef struct {
        word_t number;
        bit    prime;
    } verdict_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    word_t      s_axis_tdata  = '0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    candidate_t      candidates [$];
    verdict_t        verdicts_due [$];
    verdict_t        due;
    candidate_t      head;
    int unsigned     idle_left  = 0;
    int unsigned     stall_left = 0;
    int unsigned     total_numbers = 0;
    int unsigned     accepted_cnt  = 0;
    int unsigned     prime_cnt     = 0;
    int unsigned     checked_cnt   = 0;
    int unsigned     error_cnt     = 0;
    longint unsigned cycles        = 0;
    bit              calm          = 1'b0;
    bit              verdict;

    miller_rabin_prime_test_64 #(
        .WITNESS_COUNT(WITNESS_COUNT_DEF)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [63:0] number
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)     // [0] is_prime, [7:1] zero
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic word_t mul_mod_u64(word_t a, word_t b, word_t m);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return word_t'(prod % {64'd0, m});
    endfunction

    function automatic word_t pow_mod_u64(word_t base, word_t expo, word_t m);
        word_t acc;
        word_t b;
        word_t e;
        acc = 64'd1;
        b   = base % m;
        e   = expo;
        while (e != 64'd0) begin
            if (e[0])
                acc = mul_mod_u64(acc, b, m);
            b = mul_mod_u64(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic bit strong_probable(word_t n, word_t base);
        word_t n_less;
        word_t odd_part;
        word_t x;
        int    twos;
        if (n % base == 64'd0)
            return n == base;
        n_less   = n - 64'd1;
        odd_part = n_less;
        twos     = 0;
        while (!odd_part[0]) begin
            odd_part = odd_part >> 1;
            twos++;
        end
        x = pow_mod_u64(base, odd_part, n);
        if (x == 64'd1 || x == n_less)
            return 1'b1;
        for (int k = 1; k < twos; k++) begin
            x = mul_mod_u64(x, x, n);
            if (x == n_less)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit is_prime_u64(word_t n);
        if (n < 64'd2)
            return 1'b0;
        if (n < 64'd4)
            return 1'b1;
        if (!n[0] || n % 64'd3 == 64'd0)
            return 1'b0;
        for (int i = 0; i < WITNESS_COUNT_DEF && i < NUM_BASES; i++) begin
            if (!strong_probable(n, word_t'(BASES[i])))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic word_t random_prime(bit wide);
        word_t c;
        if (wide)
            c = {$urandom, $urandom} | 64'h8000_0000_0000_0001;
        else
            c = {32'd0, $urandom | 32'h8000_0001};
        while (!is_prime_u64(c))
            c = c + 64'd2;
        return c;
    endfunction

    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    task automatic add_number(word_t n, bit drain_first = 1'b0);
        candidate_t c;
        c.number      = n;
        c.gap         = pick_gap(calm);
        c.drain_first = drain_first;
        candidates.push_back(c);
    endtask

    // sender: present the next number once its gap has run out, after all results if drain_first
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                verdict = is_prime_u64(s_axis_tdata);
                verdicts_due.push_back('{number: s_axis_tdata, prime: verdict});
                accepted_cnt++;
                if (verdict)
                    prime_cnt++;
            end
            if (candidates.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (idle_left != 0) begin
                idle_left     <= idle_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (candidates[0].drain_first && verdicts_due.size() != 0) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                head          = candidates.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= head.number;
                if (candidates.size() != 0)
                    idle_left <= candidates[0].gap;
            end
        end
    end

    // receiver: stall at random, with quiet stretches
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!cycles[14] && $urandom_range(0, 99) < 8)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                          : $urandom_range(1, 4);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            checked_cnt++;
            if (verdicts_due.size() == 0) begin
                error_cnt++;
                if (error_cnt <= MAX_REPORTS)
                    $display("unexpected result transfer: tdata=0x%02h", m_axis_tdata);
            end else begin
                due = verdicts_due.pop_front();
                if (m_axis_tdata !== {7'd0, due.prime}) begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS)
                        $display("wrong verdict for %0d: expected is_prime=%0d, got tdata=0x%02h",
                                 due.number, due.prime, m_axis_tdata);
                end
            end
        end
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, verdicts_due.size());
        $display("miller_rabin_prime_test_64: mismatch");
        $finish;
    end

    initial begin
        word_t       n;
        int unsigned r;
        int unsigned shift;

        add_number(64'd0);
        add_number(64'd1);
        add_number(64'd2);
        add_number(64'd3);
        add_number(64'd4);
        add_number(64'd5);
        add_number(64'd9);
        add_number(64'd25);
        add_number(64'd37);
        add_number(64'd41);
        add_number(64'd561);
        add_number(64'd2047);
        add_number(64'd1373653);
        add_number(64'd25326001);
        add_number(64'd3215031751);
        add_number(64'd3825123056546413051);
        add_number(64'd2305843009213693951);
        add_number(64'hFFFF_FFEA_0000_0055);
        add_number(64'hFFFF_FFFF_FFFF_FFC5);
        add_number(64'hFFFF_FFFF_FFFF_FFFF);
        add_number(64'hFFFF_FFFF_FFFF_FFFE);
        add_number(64'h8000_0000_0000_0000);
        add_number(64'h8000_0000_0000_0001);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = ((i / 10) % 3) == 1;
            r    = $urandom_range(0, 99);
            if (r < 45) begin
                n = {$urandom, $urandom} | 64'd1;
                if (n % 64'd3 == 64'd0)
                    n = n - 64'd2;
            end else if (r < 60) begin
                shift = $urandom_range(1, 62);
                n     = ({$urandom, $urandom} << shift) | 64'd1;
            end else if (r < 72) begin
                n = random_prime(1'b0) * random_prime(1'b0);
            end else if (r < 75) begin
                n = random_prime(1'b1);
            end else if (r < 85) begin
                n = word_t'($urandom_range(0, 2000));
            end else begin
                n = {$urandom, $urandom};
            end
            add_number(n, i == 0 || $urandom_range(0, 99) < 4);
        end
        total_numbers = candidates.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt != total_numbers || verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);

        error_cnt += verdicts_due.size();
        $display("%0d numbers tested (%0d prime), %0d results checked, %0d errors",
                 accepted_cnt, prime_cnt, checked_cnt, error_cnt);
        $display("covered: screens, small primes, pseudoprimes, semiprimes, top of range");
        if (error_cnt == 0)
            $display("miller_rabin_prime_test_64: match");
        else
            $display("miller_rabin_prime_test_64: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/mrpt64_pkg.sv
hw/rtl/mrpt64_mulmod.sv
hw/rtl/miller_rabin_prime_test_64.sv
tb/miller_rabin_prime_test_64_tb.sv
